// ===== rtl/rhps_pkg.sv =====
// rhps_pkg: types, constants and codes for the RGB histogram plot scaler.
// No dependencies; imported by rhps_lane and the top level.
`timescale 1ns / 1ps
package rhps_pkg;
   localparam int BIN_COUNT_DEF   = 256;
   localparam int COUNT_WIDTH_DEF = 20;
   localparam int BIN_AW          = 8;
   localparam int LANE_COUNT      = 3;
   localparam int PEAK_OUT_W      = 20;

   localparam logic [1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [1:0] OP_QUERY      = 2'd1;
   localparam logic [1:0] OP_CLEAR      = 2'd2;

   localparam logic [1:0] CSR_X_SPAN     = 2'd0;
   localparam logic [1:0] CSR_X_ORIGIN   = 2'd1;
   localparam logic [1:0] CSR_Y_SPAN     = 2'd2;
   localparam logic [1:0] CSR_Y_BASELINE = 2'd3;

   localparam logic [9:0] X_SPAN_RST     = 10'd190;
   localparam logic [7:0] X_ORIGIN_RST   = 8'd5;
   localparam logic [7:0] Y_SPAN_RST     = 8'd54;
   localparam logic [7:0] Y_BASELINE_RST = 8'd59;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic [7:0] bin_index;
   } req_word_type;

   typedef struct packed {
      logic [10:0] x_start;
      logic [10:0] x_end;
      logic [7:0]  red_y_start;
      logic [7:0]  red_y_end;
      logic [7:0]  green_y_start;
      logic [7:0]  green_y_end;
      logic [7:0]  blue_y_start;
      logic [7:0]  blue_y_end;
      logic [19:0] peak_count;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ACC_RD, ST_ACC_WR, ST_Q_RD, ST_Q_DIV, ST_OUT
   } state_type;

   // Per-lane control from the sequencer.
   typedef struct packed {
      logic             clr_we;
      logic             rd_en;
      logic             inc_we;
      logic [BIN_AW-1:0] clr_addr;
      logic             sel_next;
   } lane_ctl_type;
endpackage

// ===== rtl/rhps_ram.sv =====
// rhps_ram: generic single-port-write, one-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module rhps_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== rtl/rhps_lane.sv =====
// rhps_lane: one color channel's bin memory with saturating increment.
// Depends on rhps_pkg and rhps_ram.
`timescale 1ns / 1ps
module rhps_lane
   import rhps_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  lane_ctl_type           ctl,
   input  logic [BIN_AW-1:0]      pix_addr,
   input  logic [BIN_AW-1:0]      q_addr,
   input  logic [BIN_AW-1:0]      q_next,
   output logic [COUNT_WIDTH-1:0] count,
   output logic [COUNT_WIDTH-1:0] bumped
);
   logic [BIN_AW-1:0]      waddr, raddr;
   logic [COUNT_WIDTH-1:0] wdata;

   always_comb begin
      bumped = (&count) ? count : count + COUNT_WIDTH'(1);
      waddr  = ctl.clr_we ? ctl.clr_addr : pix_addr;
      wdata  = ctl.clr_we ? '0 : bumped;
      raddr  = ctl.sel_next ? q_next : (ctl.rd_en ? q_addr : pix_addr);
   end

   rhps_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << BIN_AW)) u_ram (
      .clock(clock), .we(ctl.clr_we | ctl.inc_we), .waddr(waddr),
      .wdata(wdata), .raddr(raddr), .rdata(count));
endmodule

// ===== rtl/rhps_div.sv =====
// rhps_div: restoring divider giving num/den and a nonzero-remainder flag, one quotient bit a cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module rhps_div #(
   parameter int NW = 28,
   parameter int DW = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quot,
   output logic          rem_nz
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff;
   logic [CW-1:0] n_ff, n_in;
   logic [DW+1:0] trial;

   always_comb begin
      trial = {r_ff, q_ff[NW-1]} - {2'b0, d_ff};
      q_in = q_ff; r_in = r_ff; n_in = n_ff;
      if (start) begin
         q_in = num; r_in = '0; n_in = CW'(NW);
      end else if (n_ff != '0) begin
         n_in = n_ff - CW'(1);
         if (!trial[DW+1]) begin
            r_in = trial[DW:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DW-1:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in;
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
      if (start) begin
         d_ff <= den;
      end
   end

   assign busy   = (n_ff != '0);
   assign quot   = q_ff;
   assign rem_nz = (r_ff != '0);
endmodule

// ===== rtl/rgb_histogram_plot_scaler.sv =====
// rgb_histogram_plot_scaler: top level, three bin lanes, sequencer and y scaler.
// Depends on rhps_pkg, rhps_lane, rhps_div, rhps_ram.
// Throughput: one word at a time; the shared divider (one bit a cycle)
// sets query cost, the bin read-modify-write sets accumulate cost.
// Reset: registers return to defaults and a clearing pass zeroes every
// bin; no request word is taken during the pass.
`timescale 1ns / 1ps
module rgb_histogram_plot_scaler
   import rhps_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [9:0]   csr_data
);
   localparam int NW = COUNT_WIDTH + 8;

   state_type st_ff, st_in;
   logic [9:0] x_span_ff;
   logic [7:0] x_origin_ff, y_span_ff, y_base_ff;
   logic [COUNT_WIDTH-1:0] peak_ff, peak_in;
   req_word_type word_ff;
   logic [BIN_AW-1:0] clr_ff, clr_in;
   logic [2:0] k_ff, k_in;          // read step in ST_Q_RD, then which of the six y values is divided
   logic [COUNT_WIDTH-1:0] cnt_ff [6];
   logic [7:0] y_ff [6];
   logic [10:0] xs_ff, xe_ff;
   logic div_start, div_busy, div_rnz, sel_next, rd_q;
   logic div_start_q;
   logic [NW-1:0] div_q;
   lane_ctl_type ctl;
   logic [COUNT_WIDTH-1:0] lc [LANE_COUNT];
   logic [COUNT_WIDTH-1:0] lb [LANE_COUNT];
   logic [BIN_AW-1:0] pix [LANE_COUNT];
   logic [BIN_AW-1:0] q_next;
   logic [NW:0] h;

   assign csr_ready = 1'b1;
   assign q_next = (&word_ff.bin_index) ? word_ff.bin_index
                                        : word_ff.bin_index + BIN_AW'(1);
   assign pix[0] = word_ff.pixel_red;
   assign pix[1] = word_ff.pixel_green;
   assign pix[2] = word_ff.pixel_blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_span_ff <= X_SPAN_RST; x_origin_ff <= X_ORIGIN_RST;
         y_span_ff <= Y_SPAN_RST; y_base_ff <= Y_BASELINE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_X_SPAN:     x_span_ff   <= csr_data;
            CSR_X_ORIGIN:   x_origin_ff <= csr_data[7:0];
            CSR_Y_SPAN:     y_span_ff   <= csr_data[7:0];
            CSR_Y_BASELINE: y_base_ff   <= csr_data[7:0];
            default:        ;
         endcase
      end
   end

   // Each lane holds one channel; its bin is read in ST_ACC_RD, before the write in ST_ACC_WR.
   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      rhps_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane (
         .clock(clock), .ctl(ctl), .pix_addr(pix[g]),
         .q_addr(word_ff.bin_index), .q_next(q_next),
         .count(lc[g]), .bumped(lb[g]));
   end

   // Shared divider: ceil(count*y_span/peak); the operand is the slot
   // that is about to be divided.
   rhps_div #(.NW(NW), .DW(COUNT_WIDTH)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(NW'(cnt_ff[k_in]) * NW'(y_span_ff)), .den(peak_ff),
      .busy(div_busy), .quot(div_q), .rem_nz(div_rnz));

   assign h = {1'b0, div_q} + (NW+1)'(div_rnz);

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; k_in = k_ff; peak_in = peak_ff;
      ctl = '0; ctl.clr_addr = clr_ff;
      req_ready = 1'b0; rsp_valid = 1'b0; div_start = 1'b0;
      sel_next = 1'b0; rd_q = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            ctl.clr_we = 1'b1;
            clr_in = clr_ff + BIN_AW'(1);
            if (&clr_ff) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.operation)
                  OP_ACCUMULATE: st_in = ST_ACC_RD;
                  OP_QUERY:      st_in = ST_Q_RD;
                  OP_CLEAR: begin
                     st_in = ST_CLEAR; clr_in = '0; peak_in = '0;
                  end
                  default:       ;
               endcase
            end
         end
         ST_ACC_RD: st_in = ST_ACC_WR;  // read lands next cycle
         ST_ACC_WR: begin
            ctl.inc_we = 1'b1;
            for (int l = 0; l < LANE_COUNT; l++) begin
               if (lb[l] > peak_in) peak_in = lb[l];
            end
            st_in = ST_IDLE;
         end
         ST_Q_RD: begin
            // cycle k_ff=0 reads bin i, k_ff=1 reads bin i+1, then capture
            ctl.rd_en = 1'b1; sel_next = (k_ff == 3'd1);
            ctl.sel_next = sel_next;
            rd_q = 1'b1;
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd2) begin
               k_in = '0; st_in = ST_Q_DIV; div_start = (peak_ff != '0);
            end
         end
         ST_Q_DIV: begin
            if (!div_busy && !div_start) begin
               if (k_ff == 3'd5) begin
                  st_in = ST_OUT; k_in = '0;
               end else begin
                  k_in = k_ff + 3'd1; div_start = (peak_ff != '0);
               end
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; clr_ff <= '0; k_ff <= '0; peak_ff <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; k_ff <= k_in; peak_ff <= peak_in;
      end
      if (req_ready && req_valid) word_ff <= req_data;
      // capture start-bin counts (even slots) then next-bin counts (odd)
      if (rd_q && k_ff == 3'd1) begin
         for (int l = 0; l < LANE_COUNT; l++) cnt_ff[2*l] <= lc[l];
      end
      if (rd_q && k_ff == 3'd2) begin
         for (int l = 0; l < LANE_COUNT; l++) cnt_ff[2*l+1] <= lc[l];
         xs_ff <= 11'(x_origin_ff)
                + 11'((18'(word_ff.bin_index) * 18'(x_span_ff)) >> 8);
         xe_ff <= 11'(x_origin_ff)
                + 11'((19'({1'b0, word_ff.bin_index} + 9'd1) * 19'(x_span_ff)) >> 8);
      end
      // retire one y value when its division is done
      if (st_ff == ST_Q_DIV && !div_busy && !div_start_q) begin
         if (peak_ff == '0) y_ff[k_ff] <= y_base_ff;
         else if (h >= (NW+1)'(y_base_ff)) y_ff[k_ff] <= '0;
         else y_ff[k_ff] <= y_base_ff - h[7:0];
      end
   end

   // divider output is valid once busy is low and the cycle after start has passed
   always_ff @(posedge clock) begin
      if (reset) div_start_q <= 1'b0;
      else       div_start_q <= div_start;
   end

   always_comb begin
      rsp_data.x_start       = xs_ff;
      rsp_data.x_end         = xe_ff;
      rsp_data.red_y_start   = y_ff[0];
      rsp_data.red_y_end     = y_ff[1];
      rsp_data.green_y_start = y_ff[2];
      rsp_data.green_y_end   = y_ff[3];
      rsp_data.blue_y_start  = y_ff[4];
      rsp_data.blue_y_end    = y_ff[5];
      rsp_data.peak_count    = PEAK_OUT_W'(peak_ff);
   end
endmodule
